// File: design/tpe_pkg.sv
`timescale 1ns / 1ps

package tpe_pkg;

    localparam int FULL_BYTES = 20;
    localparam int MINI_BYTES = 11;
    localparam int REC_W      = FULL_BYTES * 8;
    localparam int LEN_W      = $clog2(FULL_BYTES + 1);
    localparam int MINIS_W    = 5;
    localparam int BUDGET_W   = 8;
    localparam int CFG_W      = 32;
    localparam int CFG_IW     = 1;
    localparam int QDEPTH     = 4;
    localparam int QAW        = $clog2(QDEPTH);

    typedef enum logic [CFG_IW-1:0] {
        CFG_MAX_PAYLOAD = 1'b0,
        CFG_PACKET_TIME = 1'b1
    } t_cfg_idx;

    // one encoded record, bytes left-aligned, first byte in the top bits
    typedef struct packed {
        logic [REC_W-1:0]   bytes;
        logic [LEN_W-1:0]   len;
        logic               bvalid;
        logic               slot;
        logic [MINIS_W-1:0] minis;
    } t_rec;

endpackage

// File: design/tpe_item_if.sv
`timescale 1ns / 1ps

interface tpe_item_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [31:0]        sample_time_ms;
    logic               has_fix;
    logic [7:0]         satellites;
    logic signed [30:0] latitude;
    logic signed [31:0] longitude;
    logic signed [31:0] altitude_mm;
    logic signed [31:0] speed_mm_s;
    logic signed [23:0] temp_outside;
    logic signed [23:0] temp_inside;
    logic [23:0]        pressure_pa;
    logic [15:0]        battery_raw;

    modport source (
        output valid, cmd, sample_time_ms, has_fix, satellites, latitude, longitude,
               altitude_mm, speed_mm_s, temp_outside, temp_inside, pressure_pa,
               battery_raw,
        input  ready
    );
    modport sink (
        input  valid, cmd, sample_time_ms, has_fix, satellites, latitude, longitude,
               altitude_mm, speed_mm_s, temp_outside, temp_inside, pressure_pa,
               battery_raw,
        output ready
    );
endinterface

// File: design/tpe_byte_if.sv
`timescale 1ns / 1ps

interface tpe_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
    logic       slot_taken;
    logic [4:0] minis_sent;

    modport source (
        output valid, data_byte, byte_valid, last, slot_taken, minis_sent,
        input  ready
    );
    modport sink (
        input  valid, data_byte, byte_valid, last, slot_taken, minis_sent,
        output ready
    );
endinterface

// File: design/tpe_front.sv
`timescale 1ns / 1ps

module tpe_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    tpe_item_if.sink                     i_item,
    input  logic [tpe_pkg::BUDGET_W-1:0] i_max_payload,
    input  logic [31:0]                  i_packet_time,
    output logic                         o_push,
    output tpe_pkg::t_rec                o_rec,
    input  logic                         i_q_ready
);
    import tpe_pkg::*;

    localparam int NLANES  = 8;
    localparam int LN_AGE  = 0;
    localparam int LN_LAT  = 1;
    localparam int LN_LON  = 2;
    localparam int LN_ALT  = 3;
    localparam int LN_SPD  = 4;
    localparam int LN_TOUT = 5;
    localparam int LN_TIN  = 6;
    localparam int LN_PRES = 7;

    // floor(2^33 / d): estimate is exact or one low for x < 2^33
    localparam logic [31:0] M_10   = 32'd858993459;
    localparam logic [31:0] M_100  = 32'd85899345;
    localparam logic [31:0] M_1000 = 32'd8589934;

    typedef enum logic [1:0] {
        DIV_10   = 2'd0,
        DIV_100  = 2'd1,
        DIV_1000 = 2'd2
    } t_div;

    typedef enum logic [2:0] {
        K_FULL   = 3'b001,
        K_MINI   = 3'b010,
        K_STATUS = 3'b100
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic               slot;
        logic [MINIS_W-1:0] minis;
        logic [7:0]         fixsats;
        logic [15:0]        batt;
    } t_side;

    function automatic t_div f_div_of(int lane);
        t_div d;
        case (lane)
            LN_AGE, LN_ALT:                  d = DIV_1000;
            LN_LAT, LN_LON:                  d = DIV_100;
            default:                         d = DIV_10;
        endcase
        return d;
    endfunction

    function automatic logic [31:0] f_q_est(logic [32:0] x, t_div d);
        logic [63:0] p;
        case (d)
            DIV_10:   p = 64'(x) * 64'(M_10);
            DIV_100:  p = 64'(x) * 64'(M_100);
            DIV_1000: p = 64'(x) * 64'(M_1000);
            default:  p = '0;
        endcase
        return 32'(p >> 33);
    endfunction

    function automatic logic [31:0] f_q_fix(logic [32:0] x, logic [31:0] qe, t_div d);
        logic [33:0] dv;
        logic [33:0] r;
        case (d)
            DIV_10:   dv = 34'd10;
            DIV_100:  dv = 34'd100;
            DIV_1000: dv = 34'd1000;
            default:  dv = 34'd1;
        endcase
        r = 34'(x) - 34'(qe) * dv;
        return (r >= dv) ? qe + 32'd1 : qe;
    endfunction

    function automatic logic [32:0] f_mag(logic signed [32:0] v);
        return v[32] ? 33'(33'd0 - v) : v;
    endfunction

    function automatic logic [23:0] f_sat_s24(logic [31:0] q, logic neg);
        if (neg) begin
            return (q > 32'd8388608) ? 24'h800000 : 24'(32'd0 - q);
        end
        return (q > 32'd8388607) ? 24'h7FFFFF : q[23:0];
    endfunction

    function automatic logic [15:0] f_sat_s16(logic [31:0] q, logic neg);
        if (neg) begin
            return (q > 32'd32768) ? 16'h8000 : 16'(32'd0 - q);
        end
        return (q > 32'd32767) ? 16'h7FFF : q[15:0];
    endfunction

    function automatic logic [15:0] f_sat_u16(logic [31:0] q);
        return (q > 32'd65535) ? 16'hFFFF : q[15:0];
    endfunction

    logic               adv;
    logic               acc;
    logic [MINIS_W-1:0] r_mini_slots;
    logic [MINIS_W-1:0] n_mini_slots;
    logic [8:0]         need;
    logic               budget_ok;
    t_side              n_side;
    logic [32:0]        n_x [NLANES];
    logic [NLANES-1:0]  n_neg;
    logic [31:0]        age_diff;
    logic signed [32:0] v_lat, v_lon, v_alt, v_spd, v_tout, v_tin;

    logic               r_v1, r_v2, r_v3;
    t_side              r1_side, r2_side, r3_side;
    logic [32:0]        r1_x [NLANES];
    logic [32:0]        r2_x [NLANES];
    logic [31:0]        r2_qe [NLANES];
    logic [31:0]        r3_q [NLANES];
    logic [NLANES-1:0]  r1_neg, r2_neg, r3_neg;

    // whole pipe moves together; it only holds when the queue is full
    assign adv          = !r_v3 || i_q_ready;
    assign i_item.ready = adv;
    assign acc          = i_item.valid && adv;

    // slot budget check against the count as it stands at accept
    assign need      = (9'({4'd0, r_mini_slots}) + 9'd1) * 9'(MINI_BYTES);
    assign budget_ok = (i_max_payload > BUDGET_W'(FULL_BYTES)) &&
                       (need <= 9'(i_max_payload) - 9'(FULL_BYTES));

    always_comb begin
        n_mini_slots = r_mini_slots;
        n_side.slot  = 1'b1;
        if (!i_item.cmd) begin
            n_mini_slots = '0;
            n_side.kind  = K_FULL;
        end else if (budget_ok) begin
            n_mini_slots = r_mini_slots + MINIS_W'(1);
            n_side.kind  = i_item.has_fix ? K_MINI : K_STATUS;
        end else begin
            n_side.kind  = K_STATUS;
            n_side.slot  = 1'b0;
        end
        n_side.minis   = n_mini_slots;
        n_side.fixsats = {i_item.has_fix, i_item.satellites[6:0]};
        n_side.batt    = i_item.battery_raw;
    end

    // rounding offsets go in here, magnitude first so rounding is away from zero
    always_comb begin
        age_diff = i_packet_time - i_item.sample_time_ms;
        v_lat    = {{2{i_item.latitude[30]}}, i_item.latitude};
        v_lon    = {i_item.longitude[31], i_item.longitude};
        v_alt    = {i_item.altitude_mm[31], i_item.altitude_mm};
        v_spd    = {i_item.speed_mm_s[31], i_item.speed_mm_s};
        v_tout   = {{9{i_item.temp_outside[23]}}, i_item.temp_outside};
        v_tin    = {{9{i_item.temp_inside[23]}}, i_item.temp_inside};

        n_neg          = '0;
        n_neg[LN_LAT]  = v_lat[32];
        n_neg[LN_LON]  = v_lon[32];
        n_neg[LN_TOUT] = v_tout[32];
        n_neg[LN_TIN]  = v_tin[32];

        n_x[LN_AGE]  = {1'b0, age_diff};
        n_x[LN_LAT]  = f_mag(v_lat) + 33'd50;
        n_x[LN_LON]  = f_mag(v_lon) + 33'd50;
        n_x[LN_ALT]  = v_alt[32] ? 33'd0 : v_alt + 33'd500;
        n_x[LN_SPD]  = v_spd[32] ? 33'd0 : v_spd + 33'd5;
        n_x[LN_TOUT] = f_mag(v_tout) + 33'd5;
        n_x[LN_TIN]  = f_mag(v_tin) + 33'd5;
        n_x[LN_PRES] = {9'd0, i_item.pressure_pa} + 33'd5;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mini_slots <= '0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_v3         <= 1'b0;
        end else begin
            if (acc) begin
                r_mini_slots <= n_mini_slots;
            end
            if (adv) begin
                r_v1 <= acc;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_side <= n_side;
            r2_side <= r1_side;
            r3_side <= r2_side;
            r1_neg  <= n_neg;
            r2_neg  <= r1_neg;
            r3_neg  <= r2_neg;
        end
    end

    // per lane: reciprocal estimate, then one-step correction
    for (genvar g = 0; g < NLANES; g++) begin : g_lane
        localparam t_div D = f_div_of(g);
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r1_x[g]  <= n_x[g];
                r2_x[g]  <= r1_x[g];
                r2_qe[g] <= f_q_est(r1_x[g], D);
                r3_q[g]  <= f_q_fix(r2_x[g], r2_qe[g], D);
            end
        end
    end

    // saturate and pack into the record the serializer walks through
    logic [7:0]  f_age;
    logic [23:0] f_lat, f_lon;
    logic [15:0] f_alt, f_spd, f_tout, f_tin, f_pres;

    always_comb begin
        f_age  = (r3_q[LN_AGE] > 32'd255) ? 8'hFF : r3_q[LN_AGE][7:0];
        f_lat  = f_sat_s24(r3_q[LN_LAT], r3_neg[LN_LAT]);
        f_lon  = f_sat_s24(r3_q[LN_LON], r3_neg[LN_LON]);
        f_alt  = f_sat_u16(r3_q[LN_ALT]);
        f_spd  = f_sat_u16(r3_q[LN_SPD]);
        f_tout = f_sat_s16(r3_q[LN_TOUT], r3_neg[LN_TOUT]);
        f_tin  = f_sat_s16(r3_q[LN_TIN], r3_neg[LN_TIN]);
        f_pres = f_sat_u16(r3_q[LN_PRES]);

        o_rec.slot  = r3_side.slot;
        o_rec.minis = r3_side.minis;
        case (r3_side.kind)
            K_FULL: begin
                o_rec.bytes  = {f_age, r3_side.fixsats, f_lat, f_lon, f_alt, f_spd,
                                f_tout, f_tin, f_pres, r3_side.batt};
                o_rec.len    = LEN_W'(FULL_BYTES);
                o_rec.bvalid = 1'b1;
            end
            K_MINI: begin
                o_rec.bytes  = {f_age, f_lat, f_lon, f_alt, f_spd,
                                {(REC_W - MINI_BYTES * 8){1'b0}}};
                o_rec.len    = LEN_W'(MINI_BYTES);
                o_rec.bvalid = 1'b1;
            end
            default: begin
                o_rec.bytes  = '0;
                o_rec.len    = LEN_W'(1);
                o_rec.bvalid = 1'b0;
            end
        endcase
    end

    assign o_push = r_v3 && i_q_ready;

endmodule

// File: design/tpe_queue.sv
`timescale 1ns / 1ps

module tpe_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tpe_pkg::t_rec i_wdata,
    output logic          o_wready,
    input  logic          i_pop,
    output tpe_pkg::t_rec o_rdata,
    output logic          o_rvalid
);
    import tpe_pkg::*;

    t_rec           r_mem [QDEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QAW:0]   r_cnt;
    logic           do_push;
    logic           do_pop;

    assign o_wready = (r_cnt != (QAW + 1)'(QDEPTH));
    assign o_rvalid = (r_cnt != '0);
    assign do_push  = i_push && o_wready;
    assign do_pop   = i_pop && o_rvalid;
    assign o_rdata  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + QAW'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + QAW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + (QAW + 1)'(1);
                2'b01:   r_cnt <= r_cnt - (QAW + 1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule

// File: design/tpe_back.sv
`timescale 1ns / 1ps

module tpe_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  tpe_pkg::t_rec i_q_data,
    output logic          o_q_pop,
    tpe_byte_if.source    o_byte
);
    import tpe_pkg::*;

    logic                  r_busy;
    logic [REC_W-1:0]      r_bytes;
    logic [LEN_W-1:0]      r_cnt;
    logic                  r_bvalid;
    logic                  r_slot;
    logic [MINIS_W-1:0]    r_minis;
    logic                  is_last;
    logic                  beat;
    logic                  load;

    assign is_last = (r_cnt == LEN_W'(1));
    assign beat    = r_busy && o_byte.ready;
    // next record loads on the beat that ends the current one: no gap
    assign load    = i_q_valid && (!r_busy || (beat && is_last));
    assign o_q_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_cnt  <= i_q_data.len;
        end else if (beat) begin
            r_busy <= !is_last;
            r_cnt  <= r_cnt - LEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bytes  <= i_q_data.bytes;
            r_bvalid <= i_q_data.bvalid;
            r_slot   <= i_q_data.slot;
            r_minis  <= i_q_data.minis;
        end else if (beat) begin
            r_bytes  <= r_bytes << 8;
        end
    end

    assign o_byte.valid      = r_busy;
    assign o_byte.data_byte  = r_bytes[REC_W-1 -: 8];
    assign o_byte.byte_valid = r_bvalid;
    assign o_byte.last       = is_last;
    assign o_byte.slot_taken = r_slot;
    assign o_byte.minis_sent = r_minis;

endmodule

// File: design/telemetry_packet_encoder_unit.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake        Payload
// i_item    in   valid/ready      cmd, sample_time_ms, has_fix, satellites, latitude,
//                                 longitude, altitude_mm, speed_mm_s, temp_outside,
//                                 temp_inside, pressure_pa, battery_raw
// o_byte    out  valid/ready      data_byte, byte_valid, last, slot_taken, minis_sent
// i_cfg_*   in   write enable     idx 0 max_payload, idx 1 packet_time_ms
//
// Rate: the serializer sends one beat per cycle while o_byte.ready is high; an item
//   is 20 bytes (full record), 11 (mini with fix) or 1 (status beat); that output
//   port sets the sustained rate. The front registers each item before the queue.
// Reset: synchronous, active low; clears pipe valids, queue pointers, serializer,
//   slot count; max_payload back to 51, packet time to 0.
// Stalls: a held o_byte beat freezes the serializer; the 4-entry record queue
//   absorbs it; i_item.ready drops only when that queue is full and r_v3 is set.
module telemetry_packet_encoder_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    tpe_item_if.sink                   i_item,
    tpe_byte_if.source                 o_byte,
    input  logic                       i_cfg_we,
    input  logic [tpe_pkg::CFG_IW-1:0] i_cfg_idx,
    input  logic [tpe_pkg::CFG_W-1:0]  i_cfg_data
);
    import tpe_pkg::*;

    logic [BUDGET_W-1:0] r_max_payload;
    logic [31:0]         r_packet_time;

    // the user must keep config writes to idle times; the block does not enforce it, and the front reads them live
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= BUDGET_W'(51);
            r_packet_time <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_PAYLOAD: r_max_payload <= i_cfg_data[BUDGET_W-1:0];
                CFG_PACKET_TIME: r_packet_time <= i_cfg_data[31:0];
                default:         r_max_payload <= r_max_payload;
            endcase
        end
    end

    logic q_push;
    logic q_ready;
    logic q_pop;
    logic q_valid;
    t_rec q_wdata;
    t_rec q_rdata;

    // front: accept, slot budget, field conversion (3 registered stages)
    tpe_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (i_item),
        .i_max_payload (r_max_payload),
        .i_packet_time (r_packet_time),
        .o_push        (q_push),
        .o_rec         (q_wdata),
        .i_q_ready     (q_ready)
    );

    // record queue decoupling conversion from serialization
    tpe_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_wdata  (q_wdata),
        .o_wready (q_ready),
        .i_pop    (q_pop),
        .o_rdata  (q_rdata),
        .o_rvalid (q_valid)
    );

    // back: byte serializer, MSB first
    tpe_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_rdata),
        .o_q_pop   (q_pop),
        .o_byte    (o_byte)
    );

    // front only backs off when the record queue is full
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_item.ready |-> !q_ready)
        else $error("input stalled with room in record queue");

    // a status beat stands alone and carries a zero byte
    a_status_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_byte.valid && !o_byte.byte_valid) |-> (o_byte.last && o_byte.data_byte == 8'd0))
        else $error("status beat malformed");

    // the budget never admits more than 21 minis
    a_minis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_byte.valid |-> (o_byte.minis_sent <= 5'd21))
        else $error("mini slot count out of range");

    // bytes of one record follow without a gap
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_byte.valid && o_byte.ready && !o_byte.last) |=> o_byte.valid)
        else $error("gap inside a record");

endmodule
